// File: rtl/fbc_pkg.sv
// Shared types and constants of the FIFO byte-budget cache.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package fbc_pkg;

  // Port field widths
  localparam int CMD_W      = 2;
  localparam int KEY_W      = 32;
  localparam int SIZE_W     = 32;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 6;
  localparam int IN_DATA_W  = KEY_W + SIZE_W;
  localparam int OUT_DATA_W = KEY_W + SIZE_W + STATUS_W + SIZE_W + COUNT_W;

  // Configuration port
  localparam int CFG_ADDR_W    = 1;
  localparam int CFG_DATA_W    = 32;
  localparam int CFG_BYTES_W   = 32;
  localparam int CFG_ENTRIES_W = 6;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_BYTES   = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_ENTRIES = 1'b1;
  localparam logic [CFG_BYTES_W-1:0]   RESET_MAX_BYTES   = '1;
  localparam logic [CFG_ENTRIES_W-1:0] RESET_MAX_ENTRIES = 6'd32;

  // Parameter defaults
  localparam int unsigned DEF_ENTRIES   = 32;
  localparam int unsigned DEF_KEY_BITS  = 32;
  localparam int unsigned DEF_SIZE_BITS = 32;

  localparam logic KIND_EVICT  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_RESIZE = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_TOO_BIG   = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  // Controller to datapath
  typedef struct packed {
    logic    load;
    logic    idx_clr;
    logic    idx_inc;
    logic    rd_head;
    logic    rd_idx;
    logic    rd_nxt;
    logic    wr_shift;
    logic    wr_app;
    logic    wr_pos;
    logic    pos_set;
    logic    pos_dec;
    logic    old_set;
    logic    drop;
    logic    drop_head;
    logic    emit_evict;
    logic    emit_status;
    status_t status;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    cmd_t cmd;
    logic size_over;
    logic evict_ins;
    logic fits;
    logic pos_zero;
    logic idx_end;
    logic match;
    logic out_free;
  } dp_stat_t;

  typedef struct packed {
    logic                kind;
    logic [KEY_W-1:0]    key;
    logic [SIZE_W-1:0]   size;
    status_t             status;
    logic [SIZE_W-1:0]   total;
    logic [COUNT_W-1:0]  count;
    logic                last;
  } out_t;

endpackage

// File: rtl/fbc_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on fbc_pkg for parameter defaults.
`timescale 1ns / 1ps

module fbc_ram import fbc_pkg::*; #(
  parameter int unsigned WIDTH = DEF_KEY_BITS + DEF_SIZE_BITS,
  parameter int unsigned DEPTH = DEF_ENTRIES,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/fbc_ctrl.sv
// Sequencer of the FIFO byte-budget cache: walks insert, resize and remove.
// Depends on fbc_pkg; drives fbc_dp through dp_cmd_t and reads dp_stat_t.
`timescale 1ns / 1ps

module fbc_ctrl import fbc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_INS_CHK, S_INS_EVICT, S_FIND, S_FIND_CMP,
    S_RS_CHK, S_RS_EVH, S_RS_SCAN, S_RS_SCMP, S_SHIFT, S_SHIFT_WR,
    S_RS_WR, S_STATUS
  } state_t;

  state_t  state, state_next;
  status_t st, st_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.status = st;
    state_next = state;
    st_next    = st;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat.cmd)
          CMD_INSERT: begin
            if (stat.size_over) begin
              st_next    = ST_TOO_BIG;
              state_next = S_STATUS;
            end else begin
              state_next = S_INS_CHK;
            end
          end
          CMD_RESIZE: begin
            if (stat.size_over) begin
              st_next    = ST_TOO_BIG;
              state_next = S_STATUS;
            end else begin
              cmd.idx_clr = 1'b1;
              state_next  = S_FIND;
            end
          end
          CMD_REMOVE: begin
            cmd.idx_clr = 1'b1;
            state_next  = S_FIND;
          end
          default: begin
            st_next    = ST_OK;
            state_next = S_STATUS;
          end
        endcase
      end
      S_INS_CHK: begin
        if (stat.evict_ins) begin
          cmd.rd_head = 1'b1;
          state_next  = S_INS_EVICT;
        end else begin
          cmd.wr_app = 1'b1;
          st_next    = ST_OK;
          state_next = S_STATUS;
        end
      end
      S_INS_EVICT: begin
        if (stat.out_free) begin
          cmd.drop       = 1'b1;
          cmd.drop_head  = 1'b1;
          cmd.emit_evict = 1'b1;
          state_next     = S_INS_CHK;
        end
      end
      S_FIND: begin
        if (stat.idx_end) begin
          st_next    = ST_NOT_FOUND;
          state_next = S_STATUS;
        end else begin
          cmd.rd_idx = 1'b1;
          state_next = S_FIND_CMP;
        end
      end
      S_FIND_CMP: begin
        if (!stat.match) begin
          cmd.idx_inc = 1'b1;
          state_next  = S_FIND;
        end else if (stat.cmd == CMD_RESIZE) begin
          cmd.pos_set = 1'b1;
          cmd.old_set = 1'b1;
          state_next  = S_RS_CHK;
        end else begin
          // remove: drop in place, then close the gap
          cmd.drop   = 1'b1;
          state_next = S_SHIFT;
        end
      end
      S_RS_CHK: begin
        if (stat.fits) begin
          state_next = S_RS_WR;
        end else if (!stat.pos_zero) begin
          cmd.rd_head = 1'b1;
          state_next  = S_RS_EVH;
        end else begin
          cmd.idx_clr = 1'b1;
          state_next  = S_RS_SCAN;
        end
      end
      S_RS_EVH: begin
        if (stat.out_free) begin
          cmd.drop       = 1'b1;
          cmd.drop_head  = 1'b1;
          cmd.emit_evict = 1'b1;
          cmd.pos_dec    = 1'b1;
          state_next     = S_RS_CHK;
        end
      end
      S_RS_SCAN: begin
        if (stat.idx_end) begin
          state_next = S_RS_WR;
        end else begin
          cmd.rd_idx = 1'b1;
          state_next = S_RS_SCMP;
        end
      end
      S_RS_SCMP: begin
        if (stat.match) begin
          cmd.idx_inc = 1'b1;
          state_next  = S_RS_SCAN;
        end else if (stat.out_free) begin
          cmd.drop       = 1'b1;
          cmd.emit_evict = 1'b1;
          state_next     = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (!stat.idx_end) begin
          cmd.rd_nxt = 1'b1;
          state_next = S_SHIFT_WR;
        end else if (stat.cmd == CMD_RESIZE) begin
          state_next = S_RS_CHK;
        end else begin
          st_next    = ST_OK;
          state_next = S_STATUS;
        end
      end
      S_SHIFT_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.idx_inc  = 1'b1;
        state_next   = S_SHIFT;
      end
      S_RS_WR: begin
        cmd.wr_pos = 1'b1;
        st_next    = ST_OK;
        state_next = S_STATUS;
      end
      S_STATUS: begin
        if (stat.out_free) begin
          cmd.emit_status = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      st    <= ST_OK;
    end else begin
      state <= state_next;
      st    <= st_next;
    end
  end

endmodule

// File: rtl/fbc_dp.sv
// Datapath of the FIFO byte-budget cache: ring pointers, byte total,
// limit compares, RAM addressing and the output register. Uses fbc_pkg.
`timescale 1ns / 1ps

module fbc_dp import fbc_pkg::*; #(
  parameter int unsigned ENTRIES   = DEF_ENTRIES,
  parameter int unsigned KEY_BITS  = DEF_KEY_BITS,
  parameter int unsigned SIZE_BITS = DEF_SIZE_BITS,
  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int DW = KEY_BITS + SIZE_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [CFG_DATA_W-1:0]    cfg_wdata,
  input  logic [CMD_W-1:0]         in_cmd,
  input  logic [KEY_W-1:0]         in_key,
  input  logic [SIZE_W-1:0]        in_size,
  input  dp_cmd_t                  cmd,
  output dp_stat_t                 stat,
  output logic                     ram_wr_en,
  output logic [AW-1:0]            ram_wr_addr,
  output logic [DW-1:0]            ram_wr_data,
  output logic                     ram_rd_en,
  output logic [AW-1:0]            ram_rd_addr,
  input  logic [DW-1:0]            ram_rd_data,
  input  logic                     out_ready,
  output logic                     out_valid,
  output out_t                     out_item
);

  localparam int OW = $clog2(ENTRIES + 1);
  localparam int SW = ((AW > OW) ? AW : OW) + 1;
  localparam int CW = (SIZE_BITS > CFG_BYTES_W) ? SIZE_BITS : CFG_BYTES_W;
  localparam int LW = (OW > CFG_ENTRIES_W) ? OW : CFG_ENTRIES_W;

  logic [CFG_BYTES_W-1:0]   max_bytes;
  logic [CFG_ENTRIES_W-1:0] max_entries;
  logic [AW-1:0]            head;
  logic [OW-1:0]            occ;
  logic [SIZE_BITS-1:0]     total;
  logic [OW-1:0]            idx;
  logic [OW-1:0]            pos;
  logic [SIZE_BITS-1:0]     old;
  logic [CMD_W-1:0]         req_cmd;
  logic [KEY_BITS-1:0]      req_key;
  logic [SIZE_BITS-1:0]     req_size;

  logic [KEY_BITS-1:0]  rd_key;
  logic [SIZE_BITS-1:0] rd_size;
  logic [LW-1:0]        lim;
  logic [CW-1:0]        maxb_x, size_x, tot_x, rest_x;
  logic [SIZE_BITS-1:0] rest, tot_drop, tot_app, tot_rs;
  logic [OW-1:0]        occ_drop;
  logic                 over_b;

  // Logical slot (0 = oldest) to RAM address
  function automatic logic [AW-1:0] phys(input logic [OW-1:0] l);
    logic [SW-1:0] s;
    s = SW'(head) + SW'(l);
    if (s >= SW'(ENTRIES)) s = s - SW'(ENTRIES);
    return s[AW-1:0];
  endfunction

  function automatic logic [SIZE_BITS-1:0] sat_add(input logic [SIZE_BITS-1:0] a,
                                                   input logic [SIZE_BITS-1:0] b);
    logic [SIZE_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SIZE_BITS] ? '1 : s[SIZE_BITS-1:0];
  endfunction

  assign rd_key  = ram_rd_data[DW-1 -: KEY_BITS];
  assign rd_size = ram_rd_data[SIZE_BITS-1:0];

  always_comb begin
    lim = LW'(max_entries);
    if (lim == '0) lim = LW'(1);
    if (lim > LW'(ENTRIES)) lim = LW'(ENTRIES);
  end

  assign maxb_x = CW'(max_bytes);
  assign size_x = CW'(req_size);
  assign tot_x  = CW'(total);
  assign rest   = (total >= old) ? total - old : '0;
  assign rest_x = CW'(rest);
  assign over_b = (tot_x > maxb_x) || (size_x > maxb_x - tot_x);

  assign occ_drop = occ - OW'(1);
  assign tot_drop = (occ_drop == '0) ? '0 : ((total >= rd_size) ? total - rd_size : '0);
  assign tot_app  = sat_add(total, req_size);
  assign tot_rs   = sat_add(rest, req_size);

  always_comb begin
    stat.cmd       = cmd_t'(req_cmd);
    stat.size_over = size_x > maxb_x;
    stat.evict_ins = (occ != '0) && ((LW'(occ) >= lim) || over_b);
    stat.fits      = !((rest_x > maxb_x) || (size_x > maxb_x - rest_x));
    stat.pos_zero  = (pos == '0);
    stat.idx_end   = (idx >= occ);
    stat.match     = (rd_key == req_key);
    stat.out_free  = !out_valid || out_ready;
  end

  // RAM ports
  always_comb begin
    ram_rd_en   = cmd.rd_head | cmd.rd_idx | cmd.rd_nxt;
    ram_rd_addr = phys(idx);
    if (cmd.rd_head) ram_rd_addr = phys('0);
    if (cmd.rd_nxt)  ram_rd_addr = phys(idx + OW'(1));
    ram_wr_en   = cmd.wr_shift | cmd.wr_app | cmd.wr_pos;
    ram_wr_addr = phys(idx);
    ram_wr_data = {req_key, req_size};
    if (cmd.wr_shift) ram_wr_data = ram_rd_data;
    if (cmd.wr_app)   ram_wr_addr = phys(occ);
    if (cmd.wr_pos)   ram_wr_addr = phys(pos);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      max_bytes   <= RESET_MAX_BYTES;
      max_entries <= RESET_MAX_ENTRIES;
      head        <= '0;
      occ         <= '0;
      total       <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_addr)
          REG_MAX_BYTES:   max_bytes   <= cfg_wdata[CFG_BYTES_W-1:0];
          REG_MAX_ENTRIES: max_entries <= cfg_wdata[CFG_ENTRIES_W-1:0];
          default: ;
        endcase
      end
      if (cmd.drop) begin
        occ   <= occ_drop;
        total <= tot_drop;
      end
      if (cmd.drop_head) head <= phys(OW'(1));
      if (cmd.wr_app) begin
        occ   <= occ + OW'(1);
        total <= tot_app;
      end
      if (cmd.wr_pos) total <= tot_rs;
      if (cmd.emit_evict || cmd.emit_status) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_cmd  <= in_cmd;
      req_key  <= KEY_BITS'(in_key);
      req_size <= SIZE_BITS'(in_size);
    end
    if (cmd.idx_clr) idx <= '0;
    if (cmd.idx_inc) idx <= idx + OW'(1);
    if (cmd.pos_set) pos <= idx;
    if (cmd.pos_dec) pos <= pos - OW'(1);
    if (cmd.old_set) old <= rd_size;
    if (cmd.emit_evict) begin
      out_item.kind   <= KIND_EVICT;
      out_item.key    <= KEY_W'(rd_key);
      out_item.size   <= SIZE_W'(rd_size);
      out_item.status <= ST_OK;
      out_item.total  <= SIZE_W'(tot_drop);
      out_item.count  <= COUNT_W'(occ_drop);
      out_item.last   <= 1'b0;
    end else if (cmd.emit_status) begin
      out_item.kind   <= KIND_STATUS;
      out_item.key    <= '0;
      out_item.size   <= '0;
      out_item.status <= cmd.status;
      out_item.total  <= SIZE_W'(total);
      out_item.count  <= COUNT_W'(occ);
      out_item.last   <= 1'b1;
    end
  end

endmodule

// File: rtl/fifo_byte_budget_cache.sv
// Top level of the FIFO byte-budget cache: ports, controller, datapath, RAM.
// Depends on fbc_pkg, fbc_ram, fbc_ctrl and fbc_dp.
`timescale 1ns / 1ps

// FIFO cache bookkeeping under a byte budget and an entry-count limit.
// Input channel (s_*): one transaction carries a command (tuser) and a key and
// byte size (tdata). Output channel (m_*): every command yields zero or more
// eviction reports followed by one status result marked by tlast.
// Configuration: cfg_wr_en/cfg_addr/cfg_wdata write max_bytes (0) or
// max_entries (1); write only while the block is idle.
// Entries live in a ring buffer in one RAM; evicting the oldest entry just
// advances the head pointer, a deletion from the middle closes the gap by
// moving later entries down one slot.
// One item is handled at a time. An insert evicts the oldest entries as needed,
// then writes its entry and shows its status result. A key search reads one
// slot at a time through the single RAM read port, and a middle deletion moves
// one entry at a time.
// The output register lets the next transaction enter while the last status
// waits; the sequencer stalls whenever a new result finds it still full.
// Reset clears the store to empty and restores max_bytes to all ones and
// max_entries to 32; no clearing pass is needed.

module fifo_byte_budget_cache import fbc_pkg::*; #(
  parameter int unsigned ENTRIES   = DEF_ENTRIES,
  parameter int unsigned KEY_BITS  = DEF_KEY_BITS,
  parameter int unsigned SIZE_BITS = DEF_SIZE_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // key, item_size
  input  logic [CMD_W-1:0]      s_tuser,   // command
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // evicted_key, evicted_size, status,
                                           // total_bytes, entry_count
  output logic                  m_tuser,   // kind
  output logic                  m_tlast    // last
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int DW = KEY_BITS + SIZE_BITS;
  localparam int ST_LO = KEY_W + SIZE_W;

  dp_cmd_t        cmd;
  dp_stat_t       stat;
  out_t           out_item;
  logic           ram_wr_en, ram_rd_en;
  logic [AW-1:0]  ram_wr_addr, ram_rd_addr;
  logic [DW-1:0]  ram_wr_data, ram_rd_data;

  fbc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fbc_dp #(
    .ENTRIES   (ENTRIES),
    .KEY_BITS  (KEY_BITS),
    .SIZE_BITS (SIZE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .in_cmd      (s_tuser),
    .in_key      (s_tdata[KEY_W-1:0]),
    .in_size     (s_tdata[KEY_W +: SIZE_W]),
    .cmd         (cmd),
    .stat        (stat),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data),
    .out_ready   (m_tready),
    .out_valid   (m_tvalid),
    .out_item    (out_item)
  );

  // Key and size of each entry share one RAM word
  fbc_ram #(
    .WIDTH (DW),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Pack the result fields, lowest first
  assign m_tdata = {out_item.count, out_item.total, out_item.status,
                    out_item.size, out_item.key};
  assign m_tuser = out_item.kind;
  assign m_tlast = out_item.last;

  // An eviction report is never last and always carries an ok status
  a_evict_fmt: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_EVICT) |->
      !m_tlast && (m_tdata[ST_LO +: STATUS_W] == ST_OK))
    else $error("eviction report with last or nonzero status");

  // The status result closes the transaction and carries no entry
  a_status_fmt: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_STATUS) |->
      m_tlast && (m_tdata[ST_LO-1:0] == '0))
    else $error("status result malformed");

  // One command at a time: accepting an item closes the input
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while a command is in progress");

endmodule
